/* src/bphb_pkg.sv */
`default_nettype none
package bphb_pkg;

	localparam int BAR_BITS  = 8;
	localparam int TIME_BITS = 32;
	localparam int PWR_BITS  = 16;
	localparam int CFG_BITS  = 16;
	localparam int IDX_BITS  = 2;
	localparam int CNT_BITS  = 8;

	// register indexes
	localparam logic [IDX_BITS-1:0] REG_PEAK_MODE  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_SCALE_FULL = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_ZOOM_LIMIT = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_FULL_LIMIT = 2'd3;

	localparam logic [PWR_BITS-1:0] ZOOM_LIMIT_RST = 16'd250;
	localparam logic [PWR_BITS-1:0] FULL_LIMIT_RST = 16'd2500;

	localparam logic [TIME_BITS-1:0] COOL_SLOW  = TIME_BITS'(300);
	localparam logic [TIME_BITS-1:0] COOL_MID   = TIME_BITS'(150);
	localparam logic [TIME_BITS-1:0] COOL_FAST  = TIME_BITS'(50);
	localparam logic [TIME_BITS-1:0] BLINK_TIME = TIME_BITS'(250);

	localparam logic [BAR_BITS-1:0] BLINK_RST = BAR_BITS'(8'h50);
	localparam logic [BAR_BITS-1:0] OVER_BASE = BAR_BITS'(8'h0f);

	typedef struct packed {
		logic                peak_mode;
		logic                scale_full;
		logic [PWR_BITS-1:0] zoom_limit;
		logic [PWR_BITS-1:0] full_limit;
	} cfg_t;

	typedef struct packed {
		logic [BAR_BITS-1:0]  new_upper;
		logic [BAR_BITS-1:0]  new_lower;
		logic [TIME_BITS-1:0] now_ms;
		logic                 rf_present;
		logic [PWR_BITS-1:0]  forward_power;
		logic                 update_allowed;
		logic                 skip_peak;
	} item_t;

	typedef struct packed {
		logic                write_frame;
		logic                clear_display;
		logic [BAR_BITS-1:0] out_upper;
		logic [BAR_BITS-1:0] out_lower;
	} res_t;

endpackage
`default_nettype wire

/* src/bphb_cfg_regs.sv */
`default_nettype none
module bphb_cfg_regs
	import bphb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_mode  <= 1'b0;
			cfg_q.scale_full <= 1'b0;
			cfg_q.zoom_limit <= ZOOM_LIMIT_RST;
			cfg_q.full_limit <= FULL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PEAK_MODE:  cfg_q.peak_mode  <= cfg_data[0];
				REG_SCALE_FULL: cfg_q.scale_full <= cfg_data[0];
				REG_ZOOM_LIMIT: cfg_q.zoom_limit <= cfg_data[PWR_BITS-1:0];
				REG_FULL_LIMIT: cfg_q.full_limit <= cfg_data[PWR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* src/bphb_in_stage.sv */
`default_nettype none
module bphb_in_stage
	import bphb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  item_t     in_item,
	input  wire logic advance,
	output logic      item_vld,
	output item_t     item
);

	logic  vld_s1;
	item_t item_s1;

	assign in_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	assign item_vld = vld_s1;
	assign item     = item_s1;

endmodule
`default_nettype wire

/* src/bphb_core.sv */
`default_nettype none
module bphb_core
	import bphb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  item_t     item,
	input  wire logic fire,
	output res_t      res
);

	logic [BAR_BITS-1:0]  held_upper_q, held_lower_q, blink_q;
	logic [CNT_BITS-1:0]  decay_count_q;
	logic [TIME_BITS-1:0] last_decay_q, last_blink_q;
	logic                 clear_pending_q;

	logic                 use_peak, shift, over, blink_flip, nonzero, wr, clr_drop;
	logic [TIME_BITS-1:0] decay_elapsed, blink_elapsed, cooldown;
	logic [BAR_BITS-1:0]  held_up_sh, held_lo_sh, up, lo;
	logic [PWR_BITS-1:0]  limit;
	logic [CNT_BITS-1:0]  count_next;

	always_comb begin
		use_peak      = !item.skip_peak && cfg.peak_mode;
		decay_elapsed = item.now_ms - last_decay_q;
		if (decay_count_q < CNT_BITS'(2)) begin
			cooldown = COOL_SLOW;
		end else if (decay_count_q < CNT_BITS'(4)) begin
			cooldown = COOL_MID;
		end else begin
			cooldown = COOL_FAST;
		end
		shift      = use_peak && (decay_elapsed > cooldown);
		held_up_sh = shift ? (held_upper_q >> 1) : held_upper_q;
		held_lo_sh = shift ? (held_lower_q >> 1) : held_lower_q;

		count_next = shift ? decay_count_q + CNT_BITS'(1) : decay_count_q;
		// RF presence restarts the slow decay unless this request skips peak
		if (!item.skip_peak && item.rf_present) begin
			count_next = '0;
		end

		up = item.new_upper;
		lo = item.new_lower;
		if (use_peak) begin
			up = up | held_up_sh;
			lo = lo | held_lo_sh;
		end

		limit         = cfg.scale_full ? cfg.full_limit : cfg.zoom_limit;
		over          = item.forward_power > limit;
		blink_elapsed = item.now_ms - last_blink_q;
		blink_flip    = over && (blink_elapsed >= BLINK_TIME);
		if (over) begin
			up = OVER_BASE | blink_q;
		end

		nonzero  = (up | lo) != '0;
		wr       = (item.rf_present || nonzero) && item.update_allowed;
		clr_drop = !item.rf_present && !nonzero && clear_pending_q;

		res.write_frame   = wr;
		res.clear_display = clr_drop && item.update_allowed;
		res.out_upper     = up;
		res.out_lower     = lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_upper_q    <= '0;
			held_lower_q    <= '0;
			decay_count_q   <= '0;
			last_decay_q    <= '0;
			blink_q         <= BLINK_RST;
			last_blink_q    <= '0;
			clear_pending_q <= 1'b0;
		end else if (fire) begin
			decay_count_q <= count_next;
			if (shift) begin
				last_decay_q <= item.now_ms;
			end
			if (blink_flip) begin
				last_blink_q <= item.now_ms;
				blink_q      <= ~blink_q;
			end
			if (wr) begin
				held_upper_q    <= up;
				held_lower_q    <= lo;
				clear_pending_q <= 1'b1;
			end else begin
				held_upper_q <= held_up_sh;
				held_lower_q <= held_lo_sh;
				if (clr_drop) begin
					clear_pending_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* src/bphb_out_stage.sv */
`default_nettype none
module bphb_out_stage
	import bphb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_vld,
	input  res_t      res,
	output logic      advance,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_res
);

	logic vld_q;
	res_t res_q;

	// take a new result when the register is empty or being drained
	assign advance = !vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			res_q <= res;
		end
	end

	assign out_valid = vld_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

/* src/bargraph_peak_hold_blink_unit.sv */
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   new_upper, new_lower, now_ms, rf_present,
//                                             forward_power, update_allowed, skip_peak
// out       output     out_valid / out_stall write_frame, clear_display, out_upper, out_lower
// cfg       input      cfg_we                cfg_index, cfg_data
//
// One request per cycle when not stalled; input register feeds result register.
// Peak, decay and blink state update in the cycle a request moves to the result register.
// arst_n resets valid flags and core state and loads the register defaults at once.
// A stall on the output backs up into in_stall only when both stages hold a request.
`default_nettype none
module bargraph_peak_hold_blink_unit
	import bphb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BAR_BITS-1:0]  new_upper,
	input  wire logic [BAR_BITS-1:0]  new_lower,
	input  wire logic [TIME_BITS-1:0] now_ms,
	input  wire logic                 rf_present,
	input  wire logic [PWR_BITS-1:0]  forward_power,
	input  wire logic                 update_allowed,
	input  wire logic                 skip_peak,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      write_frame,
	output logic                      clear_display,
	output logic [BAR_BITS-1:0]       out_upper,
	output logic [BAR_BITS-1:0]       out_lower,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_BITS-1:0]  cfg_data
);

	cfg_t  cfg;
	item_t in_item, item;
	res_t  res, out_res;
	logic  item_vld, advance;

	always_comb begin
		in_item.new_upper      = new_upper;
		in_item.new_lower      = new_lower;
		in_item.now_ms         = now_ms;
		in_item.rf_present     = rf_present;
		in_item.forward_power  = forward_power;
		in_item.update_allowed = update_allowed;
		in_item.skip_peak      = skip_peak;
	end

	bphb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bphb_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.item_vld (item_vld),
		.item     (item)
	);

	bphb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.fire   (item_vld && advance),
		.res    (res)
	);

	bphb_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_vld   (item_vld),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign write_frame   = out_res.write_frame;
	assign clear_display = out_res.clear_display;
	assign out_upper     = out_res.out_upper;
	assign out_lower     = out_res.out_lower;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import bphb_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	localparam logic [TIME_BITS-1:0] SLOW_MS  = 300;
	localparam logic [TIME_BITS-1:0] MID_MS   = 150;
	localparam logic [TIME_BITS-1:0] FAST_MS  = 50;
	localparam logic [TIME_BITS-1:0] BLINK_MS = 250;
	localparam logic [BAR_BITS-1:0]  BLINK_START = 8'h50;
	localparam logic [BAR_BITS-1:0]  OVER_MASK   = 8'h0f;
	localparam logic [PWR_BITS-1:0]  ZOOM_DEFAULT = 16'd250;
	localparam logic [PWR_BITS-1:0]  FULL_DEFAULT = 16'd2500;

	// Tracks peak, decay and blink state and queues the frame each request should produce.
	class frame_predictor;
		cfg_t                 regs;
		logic [BAR_BITS-1:0]  held_up, held_lo, blink;
		logic [CNT_BITS-1:0]  decay_cnt;
		logic [TIME_BITS-1:0] last_decay, last_blink;
		bit                   clr_pending;
		res_t                 frames_due[$];
		int mismatches, n_updates, n_writes, n_clears, n_over, n_decays, n_wraps;

		function new();
			regs.peak_mode  = 1'b0;
			regs.scale_full = 1'b0;
			regs.zoom_limit = ZOOM_DEFAULT;
			regs.full_limit = FULL_DEFAULT;
			held_up = '0;
			held_lo = '0;
			blink = BLINK_START;
			decay_cnt = '0;
			last_decay = '0;
			last_blink = '0;
			clr_pending = 1'b0;
			mismatches = 0;
			n_updates = 0;
			n_writes = 0;
			n_clears = 0;
			n_over = 0;
			n_decays = 0;
			n_wraps = 0;
		endfunction

		function void set_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
			case (idx)
				REG_PEAK_MODE:  regs.peak_mode = val[0];
				REG_SCALE_FULL: regs.scale_full = val[0];
				REG_ZOOM_LIMIT: regs.zoom_limit = val;
				REG_FULL_LIMIT: regs.full_limit = val;
				default: ;
			endcase
		endfunction

		function void take_update(item_t it);
			logic [BAR_BITS-1:0]  up, lo;
			logic [TIME_BITS-1:0] since, cool;
			logic [PWR_BITS-1:0]  limit;
			bit                   nonzero;
			res_t                 r;
			up = it.new_upper;
			lo = it.new_lower;
			r = '0;
			if (!it.skip_peak) begin
				if (regs.peak_mode) begin
					since = it.now_ms - last_decay;
					cool = (decay_cnt < 2) ? SLOW_MS : (decay_cnt < 4) ? MID_MS : FAST_MS;
					if (since > cool) begin
						last_decay = it.now_ms;
						if (decay_cnt == '1)
							n_wraps++;
						decay_cnt = decay_cnt + 1'b1;
						held_up = held_up >> 1;
						held_lo = held_lo >> 1;
						n_decays++;
					end
					up = up | held_up;
					lo = lo | held_lo;
				end
				if (it.rf_present)
					decay_cnt = '0;
			end
			limit = regs.scale_full ? regs.full_limit : regs.zoom_limit;
			if (it.forward_power > limit) begin
				up = OVER_MASK | blink;
				n_over++;
				since = it.now_ms - last_blink;
				if (since >= BLINK_MS) begin
					last_blink = it.now_ms;
					blink = ~blink;
				end
			end
			nonzero = (up | lo) != '0;
			if ((it.rf_present || nonzero) && it.update_allowed) begin
				r.write_frame = 1'b1;
				clr_pending = 1'b1;
				held_up = up;
				held_lo = lo;
				n_writes++;
			end
			if (!it.rf_present && !nonzero && clr_pending) begin
				clr_pending = 1'b0;
				r.clear_display = it.update_allowed;
				if (it.update_allowed)
					n_clears++;
			end
			r.out_upper = up;
			r.out_lower = lo;
			frames_due.push_back(r);
			n_updates++;
		endfunction

		function void match_frame(res_t got);
			res_t want;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request outstanding: wr=%0b clr=%0b up=%h lo=%h",
						$realtime, got.write_frame, got.clear_display, got.out_upper, got.out_lower);
				return;
			end
			want = frames_due.pop_front();
			if (got.write_frame !== want.write_frame || got.clear_display !== want.clear_display ||
			    got.out_upper !== want.out_upper || got.out_lower !== want.out_lower) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp wr=%0b clr=%0b up=%h lo=%h  got wr=%0b clr=%0b up=%h lo=%h",
						$realtime, want.write_frame, want.clear_display, want.out_upper,
						want.out_lower, got.write_frame, got.clear_display, got.out_upper,
						got.out_lower);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [BAR_BITS-1:0]  new_upper;
	logic [BAR_BITS-1:0]  new_lower;
	logic [TIME_BITS-1:0] now_ms;
	logic                 rf_present;
	logic [PWR_BITS-1:0]  forward_power;
	logic                 update_allowed;
	logic                 skip_peak;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 write_frame;
	logic                 clear_display;
	logic [BAR_BITS-1:0]  out_upper;
	logic [BAR_BITS-1:0]  out_lower;
	logic                 cfg_we;
	logic [IDX_BITS-1:0]  cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;

	frame_predictor       ledger = new();
	int                   cycles = 0;
	int                   items_sent = 0;
	int                   burst_left = 0;
	int                   stall_left = 0;
	int                   stall_mode = 0;
	int                   reg_writes = 0;
	bit                   bursty = 1'b1;
	logic [TIME_BITS-1:0] clock_ms = '0;

	bargraph_peak_hold_blink_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_upper(new_upper),
		.new_lower(new_lower),
		.now_ms(now_ms),
		.rf_present(rf_present),
		.forward_power(forward_power),
		.update_allowed(update_allowed),
		.skip_peak(skip_peak),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_frame(write_frame),
		.clear_display(clear_display),
		.out_upper(out_upper),
		.out_lower(out_lower),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, ledger.frames_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.match_frame('{write_frame, clear_display, out_upper, out_lower});
	end

	// Receiver backpressure: switch between free flow, light, heavy and periodic stalls.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall = 1'b0;
			1: out_stall = ($urandom_range(0, 3) == 0);
			2: out_stall = ($urandom_range(0, 3) != 0);
			default: out_stall = ((cycles % 7) < 3);
		endcase
	end

	function automatic item_t mk(logic [BAR_BITS-1:0] up, logic [BAR_BITS-1:0] lo,
		logic [TIME_BITS-1:0] t, bit rf, logic [PWR_BITS-1:0] pw, bit ok, bit skp);
		item_t it;
		it.new_upper = up;
		it.new_lower = lo;
		it.now_ms = t;
		it.rf_present = rf;
		it.forward_power = pw;
		it.update_allowed = ok;
		it.skip_peak = skp;
		return it;
	endfunction

	// Hold the request until taken, then record it. Called and returns at a falling edge.
	task push_request(input item_t it);
		in_valid = 1'b1;
		new_upper = it.new_upper;
		new_lower = it.new_lower;
		now_ms = it.now_ms;
		rf_present = it.rf_present;
		forward_power = it.forward_power;
		update_allowed = it.update_allowed;
		skip_peak = it.skip_peak;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ledger.take_update(it);
		items_sent++;
		@(negedge clk);
	endtask

	task idle(input int n);
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task send(input item_t it);
		if (bursty && burst_left == 0) begin
			idle($urandom_range(0, 6));
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		push_request(it);
	endtask

	// Wait out every outstanding result plus the pipeline depth.
	task drain();
		in_valid = 1'b0;
		while (ledger.frames_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task cfg_write(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		ledger.set_reg(idx, val);
		reg_writes++;
	endtask

	// RF burst with a moving bar level, then RF off with empty frames so the hold decays
	// and the display gets cleared.
	task session(input int len);
		item_t it;
		int    k, lvl, p, lim;
		lvl = $urandom_range(0, 8);
		lim = ledger.regs.scale_full ? ledger.regs.full_limit : ledger.regs.zoom_limit;
		for (k = 0; k < len; k++) begin
			clock_ms = clock_ms + $urandom_range(10, 350);
			if (k < len / 2) begin
				lvl = lvl + int'($urandom_range(0, 2)) - 1;
				if (lvl < 0)
					lvl = 0;
				if (lvl > 8)
					lvl = 8;
				if ($urandom_range(0, 3) == 0)
					p = $urandom_range(0, 65535);
				else
					p = lim + int'($urandom_range(0, 8)) - 4;
				if (p < 0)
					p = 0;
				if (p > 65535)
					p = 65535;
				it = mk(BAR_BITS'((1 << lvl) - 1), BAR_BITS'((1 << $urandom_range(0, 8)) - 1),
					clock_ms, 1'b1, PWR_BITS'(p), $urandom_range(0, 9) != 0,
					$urandom_range(0, 9) == 0);
			end else begin
				it = mk('0, '0, clock_ms, 1'b0, '0, $urandom_range(0, 9) != 0,
					$urandom_range(0, 9) == 0);
			end
			send(it);
		end
	endtask

	task noise(input int n);
		item_t it;
		int    k;
		for (k = 0; k < n; k++) begin
			it.new_upper = BAR_BITS'($urandom);
			it.new_lower = BAR_BITS'($urandom);
			it.now_ms = $urandom_range(0, 1) ? $urandom : clock_ms + $urandom_range(0, 600);
			it.rf_present = 1'($urandom_range(0, 1));
			it.forward_power = PWR_BITS'($urandom);
			it.update_allowed = 1'($urandom_range(0, 1));
			it.skip_peak = 1'($urandom_range(0, 1));
			send(it);
		end
	endtask

	// Long RF-free stretch with short steps: drives the decay count up through the slow, mid and fast cooldowns.
	task quiet_stretch(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			clock_ms = clock_ms + $urandom_range(51, 70);
			send(mk(($urandom_range(0, 3) == 0) ? '0 : BAR_BITS'($urandom),
				($urandom_range(0, 3) == 0) ? '0 : BAR_BITS'($urandom),
				clock_ms, 1'b0, '0, $urandom_range(0, 7) != 0, 1'b0));
		end
	endtask

	task run_phase(input logic [CFG_BITS-1:0] pk, input logic [CFG_BITS-1:0] sc,
		input logic [CFG_BITS-1:0] zl, input logic [CFG_BITS-1:0] fl,
		input int quota, input int quiet);
		int stop;
		drain();
		cfg_write(REG_PEAK_MODE, pk);
		cfg_write(REG_SCALE_FULL, sc);
		cfg_write(REG_ZOOM_LIMIT, zl);
		cfg_write(REG_FULL_LIMIT, fl);
		stop = items_sent + quota + quiet;
		if (quiet > 0)
			quiet_stretch(quiet);
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) < 7)
				session($urandom_range(4, 30));
			else
				noise($urandom_range(1, 5));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		new_upper = '0;
		new_lower = '0;
		now_ms = '0;
		rf_present = 1'b0;
		forward_power = '0;
		update_allowed = 1'b0;
		skip_peak = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PEAK_MODE;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: peak hold and decay, skip, blocked write, lost clear, blink, time wrap
		cfg_write(REG_PEAK_MODE, 16'd1);
		cfg_write(REG_SCALE_FULL, 16'd0);
		cfg_write(REG_ZOOM_LIMIT, ZOOM_DEFAULT);
		cfg_write(REG_FULL_LIMIT, FULL_DEFAULT);
		push_request(mk(8'hff, 8'hff, 32'd0, 1'b1, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd100, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd401, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd702, 1'b0, 16'd0, 1'b0, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1003, 1'b0, 16'd0, 1'b1, 1'b1));
		push_request(mk(8'h01, 8'h80, 32'd1010, 1'b0, 16'hffff, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1100, 1'b0, 16'hffff, 1'b1, 1'b1));
		push_request(mk(8'h00, 8'h00, 32'd1300, 1'b0, 16'd251, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1460, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1520, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1580, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1640, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'd1700, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'hf0, 8'h0f, 32'd1720, 1'b1, 16'd250, 1'b1, 1'b1));
		push_request(mk(8'h00, 8'h00, 32'd1790, 1'b0, 16'd0, 1'b0, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'hffff_ffff, 1'b1, 16'd250, 1'b1, 1'b0));
		push_request(mk(8'haa, 8'h55, 32'h0000_0010, 1'b0, 16'd251, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'h0000_0200, 1'b0, 16'd0, 1'b1, 1'b0));
		push_request(mk(8'h00, 8'h00, 32'h0000_0400, 1'b0, 16'd0, 1'b0, 1'b0));
		push_request(mk(8'hff, 8'h00, 32'h0000_0401, 1'b1, 16'd0, 1'b0, 1'b0));
		clock_ms = 32'h0000_0800;

		run_phase(16'd1, 16'd0, ZOOM_DEFAULT, FULL_DEFAULT, 80, 260);
		bursty = 1'b0;
		run_phase(16'd0, 16'd1, ZOOM_DEFAULT, FULL_DEFAULT, 100, 0);
		bursty = 1'b1;
		run_phase(16'hfffe, 16'hffff, 16'd0, 16'hffff, 80, 0);
		clock_ms = 32'hffff_f000;
		run_phase(16'd1, 16'd0, 16'hffff, 16'd0, 80, 0);
		run_phase(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom_range(0, 4000)),
			CFG_BITS'($urandom), 80, 0);

		drain();
		repeat (10) @(posedge clk);
		$display("ran %0d requests over %0d register writes: %0d writes, %0d clears",
			items_sent, reg_writes, ledger.n_writes, ledger.n_clears);
		$display("%0d overscale frames, %0d decay shifts, %0d decay count wraps, %0d mismatches",
			ledger.n_over, ledger.n_decays, ledger.n_wraps, ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.frames_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
